>>> hw/rtl/weir_flow_level_update_assert.svh
// ----------------------------------------------------------------------------
// Weir flow level update - assertion macros
// Shared concurrent check forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef WEIR_FLOW_LEVEL_UPDATE_ASSERT_SVH
`define WEIR_FLOW_LEVEL_UPDATE_ASSERT_SVH

// same-cycle implication
`define WFLU_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("weir flow level update: check failed");

// next-cycle implication
`define WFLU_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("weir flow level update: check failed");

`endif

>>> hw/rtl/wflu_pkg.sv
// ----------------------------------------------------------------------------
// Weir flow level update - package
// Payload types, unit command/result types, constants.
// ----------------------------------------------------------------------------
package wflu_pkg;

    typedef struct packed {
        logic [30:0]        cell_depth;
        logic signed [31:0] cell_ground;
        logic [30:0]        neighbour_depth;
        logic signed [31:0] neighbour_ground;
        logic [31:0]        cell_area;
        logic               last_link;
    } wflu_in_t;

    typedef struct packed {
        logic signed [31:0] link_flow;
        logic [30:0]        new_depth;
        logic               depth_ready;
    } wflu_out_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } wflu_op_t;

    typedef struct packed {
        logic        start;
        wflu_op_t    op;
        logic        sh16;   // product shift: 1 = 16, 0 = 12
        logic [51:0] a;
        logic [31:0] b;
    } wflu_cmd_t;

    typedef struct packed {
        logic        done;
        logic [47:0] value;
    } wflu_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEVEL,
        S_HEAD,
        S_LAW,
        S_SQRT,
        S_MUL_ROOT,
        S_MUL_COEF,
        S_MUL_K3,
        S_MUL_G,
        S_ACCUM,
        S_SPLIT,
        S_DIV,
        S_DIV_WAIT,
        S_OUT
    } wflu_state_t;

    localparam logic CFG_WEIR_COEF    = 1'b0;
    localparam logic CFG_CREST_OFFSET = 1'b1;

    localparam logic [15:0] COEF_RESET = 16'd1638;
    localparam logic [31:0] SQRT2G_Q16 = 32'd290288;
    localparam logic [31:0] K3_Q16     = 32'd170268;

    localparam logic [5:0] MUL_STEPS  = 6'd4;
    localparam logic [5:0] SQRT_STEPS = 6'd26;
    localparam logic [5:0] DIV_STEPS  = 6'd48;

    localparam logic [46:0] MAG_CAP  = {47{1'b1}};
    localparam logic [47:0] FLOW_CAP = 48'h0000_7FFF_FFFF;

endpackage

>>> hw/rtl/wflu_unit.sv
// ----------------------------------------------------------------------------
// Weir flow level update - shared iterative unit
// Multiply (8 bits/cycle), square root (1 digit/cycle), divide (1 bit/cycle).
// ----------------------------------------------------------------------------
module wflu_unit
    import wflu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  wflu_cmd_t cmd,
    output wflu_res_t res
);

    logic        busy_reg, busy_next;
    wflu_op_t    op_reg, op_next;
    logic        sh16_reg, sh16_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [51:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [79:0] acc_reg, acc_next;

    logic [55:0] pp;
    logic [27:0] rem_sh;
    logic [27:0] trial;
    logic [32:0] dv_sh;
    logic [79:0] prod_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        sh16_reg <= sh16_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        pp     = a_reg[47:0] * b_reg[31:24];
        rem_sh = {acc_reg[25:0], a_reg[51:50]};
        trial  = {b_reg[25:0], 2'b01};
        dv_sh  = {acc_reg[31:0], a_reg[47]};

        busy_next = busy_reg;
        op_next   = op_reg;
        sh16_next = sh16_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            sh16_next = cmd.sh16;
            a_next    = cmd.a;
            acc_next  = '0;
            case (cmd.op)
                OP_MUL:  begin cnt_next = MUL_STEPS;  b_next = cmd.b; end
                OP_SQRT: begin cnt_next = SQRT_STEPS; b_next = '0;    end
                OP_DIV:  begin cnt_next = DIV_STEPS;  b_next = cmd.b; end
                default: begin cnt_next = '0;         b_next = cmd.b; end
            endcase
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                case (op_reg)
                    OP_MUL:
                    begin
                        acc_next = {acc_reg[71:0], 8'b0} + {24'b0, pp};
                        b_next   = {b_reg[23:0], 8'b0};
                    end
                    OP_SQRT:
                    begin
                        a_next = {a_reg[49:0], 2'b00};
                        if (rem_sh >= trial)
                        begin
                            acc_next = {52'b0, rem_sh - trial};
                            b_next   = {b_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = {52'b0, rem_sh};
                            b_next   = {b_reg[30:0], 1'b0};
                        end
                    end
                    OP_DIV:
                    begin
                        if (dv_sh >= {1'b0, b_reg})
                        begin
                            acc_next = {47'b0, dv_sh - {1'b0, b_reg}};
                            a_next   = {a_reg[50:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = {47'b0, dv_sh};
                            a_next   = {a_reg[50:0], 1'b0};
                        end
                    end
                    default: acc_next = acc_reg;
                endcase
            end
        end
    end

    // result shaping: product is shifted and capped at 2^47-1
    always_comb
    begin
        prod_sh   = sh16_reg ? (acc_reg >> 16) : (acc_reg >> 12);
        res.done  = busy_reg && (cnt_reg == '0);
        case (op_reg)
            OP_MUL:  res.value = (prod_sh[79:47] != '0) ? {1'b0, MAG_CAP}
                                                         : {1'b0, prod_sh[46:0]};
            OP_SQRT: res.value = {22'b0, b_reg[25:0]};
            OP_DIV:  res.value = a_reg[47:0];
            default: res.value = '0;
        endcase
    end

    `include "weir_flow_level_update_assert.svh"

    `WFLU_ASSERT_NOW(a_start_when_free, cmd.start, !busy_reg || cnt_reg == '0)
    `WFLU_ASSERT_NEXT(a_start_busy, cmd.start, busy_reg)
    `WFLU_ASSERT_NEXT(a_done_release, res.done && !cmd.start, !busy_reg)

endmodule

>>> hw/rtl/weir_flow_level_update.sv
// ----------------------------------------------------------------------------
// Weir flow level update - top level
// Per-link weir flow (free or submerged law), running total, depth update.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in        input      in_valid/in_ready   in_data   (wflu_in_t)
//  out       output     out_valid/out_ready out_data  (wflu_out_t)
//  cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
//  A link with no flow bypasses the shared unit; a flowing link runs a
//  square root and three (free law) or four (submerged law) multiplies
//  in it, and the last link of a cell adds a division, issued from its
//  own state before the unit runs it. One item is in work at a time;
//  in_ready is high only in idle. The output register holds a result
//  until its transfer, and the sequencer waits in its last state if that
//  register is full. Reset clears the flow total and loads the register
//  defaults.
// ----------------------------------------------------------------------------
module weir_flow_level_update
    import wflu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  wflu_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output wflu_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    wflu_state_t state_reg, state_next;

    // configuration
    logic [15:0]        coef_reg;
    logic signed [31:0] crest_off_reg;

    // item and intermediates (payload, no reset)
    wflu_in_t           item_reg, item_next;
    logic signed [33:0] z1_reg, z1_next;
    logic signed [33:0] z2_reg, z2_next;
    logic signed [33:0] crest_reg, crest_next;
    logic signed [34:0] hup_reg, hup_next;
    logic signed [34:0] hdn_reg, hdn_next;
    logic signed [34:0] diff_reg, diff_next;
    logic               pos_reg, pos_next;
    logic               free_reg, free_next;
    logic [30:0]        q_reg, q_next;
    logic signed [31:0] flow_reg, flow_next;
    logic [30:0]        depth_reg, depth_next;

    // running total (control state)
    logic signed [47:0] total_reg, total_next;

    logic               out_valid_reg, out_valid_next;
    wflu_out_t          out_data_reg, out_data_next;

    wflu_cmd_t          cmd;
    wflu_res_t          res;

    // combinational helpers
    logic signed [33:0] gmax;
    logic signed [33:0] zmax, zmin;
    logic signed [36:0] lhs2, rhs3;
    logic               law_free;
    logic signed [48:0] sum;
    logic [47:0]        total_mag;
    logic [31:0]        area_eff;
    logic signed [49:0] nd;

    wflu_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            coef_reg      <= COEF_RESET;
            crest_off_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WEIR_COEF:    coef_reg      <= cfg_data[15:0];
                    CFG_CREST_OFFSET: crest_off_reg <= cfg_data;
                    default:          coef_reg      <= coef_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        z1_reg       <= z1_next;
        z2_reg       <= z2_next;
        crest_reg    <= crest_next;
        hup_reg      <= hup_next;
        hdn_reg      <= hdn_next;
        diff_reg     <= diff_next;
        pos_reg      <= pos_next;
        free_reg     <= free_next;
        q_reg        <= q_next;
        flow_reg     <= flow_next;
        depth_reg    <= depth_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        // levels and crest
        gmax = (item_reg.cell_ground >= item_reg.neighbour_ground)
             ? 34'(item_reg.cell_ground) : 34'(item_reg.neighbour_ground);
        zmax = (z1_reg >= z2_reg) ? z1_reg : z2_reg;
        zmin = (z1_reg >= z2_reg) ? z2_reg : z1_reg;
        // free law when 2*H_up > 3*H_down
        lhs2 = 37'(hup_reg) <<< 1;
        rhs3 = (37'(hdn_reg) <<< 1) + 37'(hdn_reg);
        law_free = (lhs2 > rhs3);
        // saturating accumulate
        sum = 49'(total_reg) + 49'(flow_reg);
        total_mag = total_reg[47] ? 48'(-total_reg) : 48'(total_reg);
        area_eff  = (item_reg.cell_area == '0) ? 32'd1 : item_reg.cell_area;
        nd = total_reg[47] ? (50'(item_reg.cell_depth) + 50'(res.value))
                           : (50'(item_reg.cell_depth) - 50'(res.value));

        state_next     = state_reg;
        item_next      = item_reg;
        z1_next        = z1_reg;
        z2_next        = z2_reg;
        crest_next     = crest_reg;
        hup_next       = hup_reg;
        hdn_next       = hdn_reg;
        diff_next      = diff_reg;
        pos_next       = pos_reg;
        free_next      = free_reg;
        q_next         = q_reg;
        flow_next      = flow_reg;
        depth_next     = depth_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        cmd       = '0;
        cmd.op    = OP_MUL;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                z1_next    = 34'(item_reg.cell_ground) + 34'(item_reg.cell_depth);
                z2_next    = 34'(item_reg.neighbour_ground)
                           + 34'(item_reg.neighbour_depth);
                crest_next = gmax + 34'(crest_off_reg);
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                hup_next   = 35'(zmax) - 35'(crest_reg);
                hdn_next   = 35'(zmin) - 35'(crest_reg);
                diff_next  = 35'(zmax) - 35'(zmin);
                pos_next   = (z1_reg >= z2_reg);
                state_next = S_LAW;
            end
            S_LAW:
            begin
                free_next = law_free;
                if (hup_reg > 35'sd0)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SQRT;
                    cmd.a      = law_free ? {2'b0, hup_reg[33:0], 16'b0}
                                          : {2'b0, diff_reg[33:0], 16'b0};
                    state_next = S_SQRT;
                end
                else
                begin
                    q_next     = '0;
                    state_next = S_ACCUM;
                end
            end
            S_SQRT:
            begin
                if (res.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.sh16   = 1'b1;
                    cmd.a      = free_reg ? {18'b0, hup_reg[33:0]}
                                          : {18'b0, hdn_reg[33:0]};
                    cmd.b      = res.value[31:0];
                    state_next = S_MUL_ROOT;
                end
            end
            S_MUL_ROOT:
            begin
                if (res.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.sh16   = 1'b0;
                    cmd.a      = {4'b0, res.value};
                    cmd.b      = {16'b0, coef_reg};
                    state_next = S_MUL_COEF;
                end
            end
            S_MUL_COEF:
            begin
                if (res.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.sh16   = 1'b1;
                    cmd.a      = {4'b0, res.value};
                    cmd.b      = free_reg ? SQRT2G_Q16 : K3_Q16;
                    state_next = free_reg ? S_MUL_G : S_MUL_K3;
                end
            end
            S_MUL_K3:
            begin
                if (res.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.sh16   = 1'b1;
                    cmd.a      = {4'b0, res.value};
                    cmd.b      = SQRT2G_Q16;
                    state_next = S_MUL_G;
                end
            end
            S_MUL_G:
            begin
                if (res.done)
                begin
                    q_next     = (res.value > FLOW_CAP) ? FLOW_CAP[30:0]
                                                        : res.value[30:0];
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                // positive flow leaves the cell
                flow_next  = pos_reg ? $signed({1'b0, q_reg})
                                     : -$signed({1'b0, q_reg});
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (sum[48] != sum[47])
                    total_next = sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                else
                    total_next = sum[47:0];
                if (item_reg.last_link)
                    state_next = S_DIV;
                else
                begin
                    depth_next = '0;
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                // saturated total is in place: one division launch
                cmd.start  = 1'b1;
                cmd.op     = OP_DIV;
                cmd.a      = {4'b0, total_mag};
                cmd.b      = area_eff;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (res.done)
                begin
                    if (nd < 50'sd0)
                        depth_next = '0;
                    else if (nd > 50'sd2147483647)
                        depth_next = {31{1'b1}};
                    else
                        depth_next = nd[30:0];
                    total_next = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.link_flow     = flow_reg;
                    out_data_next.new_depth     = depth_reg;
                    out_data_next.depth_ready   = item_reg.last_link;
                    state_next                  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `include "weir_flow_level_update_assert.svh"

    `WFLU_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_LEVEL)
    `WFLU_ASSERT_NOW(a_depth_zero, out_valid && !out_data.depth_ready, out_data.new_depth == '0)
    `WFLU_ASSERT_NEXT(a_total_cleared, state_reg == S_DIV_WAIT && res.done, total_reg == '0)
    `WFLU_ASSERT_NOW(a_no_cmd_idle, state_reg == S_IDLE, !cmd.start)

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Weir flow level update - testbench
// Drives link items with random idle gaps, predicts every result with a
// cycle-free model of the weir laws and depth update, and compares each
// output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import wflu_pkg::*;

    localparam int N_RANDOM = 1850;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [47:0] CAP47 = 48'h7FFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    wflu_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    wflu_out_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    weir_flow_level_update DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: shadow registers and the running flow total
    logic [15:0]        coef_shadow;
    logic signed [31:0] crest_shadow;
    logic signed [63:0] model_total;

    wflu_in_t  link_queue[$];
    wflu_out_t expected_results[$];

    int mismatches;
    int n_sent;
    int n_checked;
    int n_cells;
    int n_free;
    int n_submerged;
    int n_dry;
    int in_gap;
    int out_gap;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // floor(sqrt(v)), bitwise
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(a*b >> s), magnitude capped at 2^47-1
    function automatic logic [63:0] scaled_mul(input logic [63:0] a, input logic [63:0] b,
                                               input int s);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> s;
        if (p > 128'(CAP47))
            return 64'(CAP47);
        return p[63:0];
    endfunction

    // weir law for one link, updates the flow total
    function automatic wflu_out_t predict_link(input wflu_in_t x);
        wflu_out_t          r;
        logic signed [63:0] z_cell, z_nbr, crest, h_up, h_dn, flow, area, delta, nd;
        logic [63:0]        q;
        z_cell = 64'(x.cell_ground) + 64'(x.cell_depth);
        z_nbr  = 64'(x.neighbour_ground) + 64'(x.neighbour_depth);
        crest  = ((x.cell_ground >= x.neighbour_ground) ? 64'(x.cell_ground)
                                                       : 64'(x.neighbour_ground))
                 + 64'(crest_shadow);
        h_up = ((z_cell >= z_nbr) ? z_cell : z_nbr) - crest;
        h_dn = ((z_cell >= z_nbr) ? z_nbr : z_cell) - crest;
        flow = '0;
        if (h_up > 0)
        begin
            if (2 * h_up > 3 * h_dn)
            begin
                n_free++;
                q = scaled_mul(h_up, int_sqrt(h_up << 16), 16);
                q = scaled_mul(q, 64'(coef_shadow), 12);
            end
            else
            begin
                n_submerged++;
                q = scaled_mul(h_dn, int_sqrt((h_up - h_dn) << 16), 16);
                q = scaled_mul(q, 64'(coef_shadow), 12);
                q = scaled_mul(q, 64'(K3_Q16), 16);
            end
            q = scaled_mul(q, 64'(SQRT2G_Q16), 16);
            if (q > 64'h7FFF_FFFF)
                q = 64'h7FFF_FFFF;
            flow = (z_cell >= z_nbr) ? $signed(q) : -$signed(q);
        end
        else
            n_dry++;
        model_total = model_total + flow;
        if (model_total > $signed(64'(CAP47)))
            model_total = 64'(CAP47);
        if (model_total < -$signed(64'(CAP47)) - 1)
            model_total = -$signed(64'(CAP47)) - 1;
        r.link_flow   = flow[31:0];
        r.new_depth   = '0;
        r.depth_ready = 1'b0;
        if (x.last_link)
        begin
            area  = (x.cell_area == '0) ? 64'sd1 : $signed(64'(x.cell_area));
            delta = model_total / area;
            nd    = 64'(x.cell_depth) - delta;
            if (nd < 0)
                nd = '0;
            if (nd > 64'sh7FFF_FFFF)
                nd = 64'sh7FFF_FFFF;
            r.new_depth   = nd[30:0];
            r.depth_ready = 1'b1;
            model_total = '0;
            n_cells++;
        end
        return r;
    endfunction

    // driver: one link at a time, a random idle gap drawn for every item
    always @(posedge clk or negedge rst_n)
    begin
        int g;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            g = in_gap;
            if (in_valid && in_ready)
            begin
                expected_results = {expected_results, predict_link(in_data)};
                n_sent++;
                g = $urandom_range(0, 5);
            end
            if (g > 0)
            begin
                in_gap   <= g - 1;
                in_valid <= 1'b0;
            end
            else if (link_queue.size() > 0)
            begin
                in_gap   <= 0;
                in_data  <= link_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_gap   <= 0;
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure, compare each transfer
    always @(posedge clk or negedge rst_n)
    begin
        wflu_out_t want;
        int        g;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_checked++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", out_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.link_flow !== want.link_flow
                        || out_data.new_depth !== want.new_depth
                        || out_data.depth_ready !== want.depth_ready)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected flow %0d depth %0d rdy %0b,",
                                      " got %0d %0d %0b"},
                                     n_checked, want.link_flow, want.new_depth,
                                     want.depth_ready, out_data.link_flow,
                                     out_data.new_depth, out_data.depth_ready);
                    end
                end
                g = $urandom_range(0, 5);
                out_gap   <= g;
                out_ready <= (g == 0);
            end
            else if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= (out_gap == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [30:0] rand_depth();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h000A_0000));
        endcase
    endfunction

    function automatic logic [31:0] rand_ground();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_area();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic wflu_in_t make_link(input logic [30:0] cd, input logic [31:0] cg,
                                           input logic [30:0] nd, input logic [31:0] ng,
                                           input logic [31:0] ar, input logic lst);
        wflu_in_t x;
        x.cell_depth = cd;
        x.cell_ground = cg;
        x.neighbour_depth = nd;
        x.neighbour_ground = ng;
        x.cell_area = ar;
        x.last_link = lst;
        return x;
    endfunction

    // append one link to the pending queue
    task automatic queue_link(input wflu_in_t x);
        link_queue = {link_queue, x};
    endtask

    // wait until the block has drained, then let the pipeline settle
    task automatic wait_drained();
        while (link_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_WEIR_COEF)
            coef_shadow = val[15:0];
        else
            crest_shadow = val;
        @(posedge clk);
    endtask

    // a cell: one to six links with shared cell fields, the last one flagged; about one in ten is fully random instead
    task automatic queue_cell();
        logic [30:0] cd;
        logic [31:0] cg, ar;
        int          n;
        cd = rand_depth();
        cg = rand_ground();
        ar = rand_area();
        n  = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_link(make_link(31'($urandom), $urandom, 31'($urandom),
                                     $urandom, $urandom, 1'($urandom)));
            else
                queue_link(make_link(cd, cg, rand_depth(), rand_ground(), ar,
                                     k == n - 1));
        end
    endtask

    initial
    begin
        logic [31:0] coef_set[4];
        logic [31:0] crest_set[4];
        int          queued;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WEIR_COEF;
        cfg_data = '0;
        coef_shadow = COEF_RESET;
        crest_shadow = '0;
        model_total = '0;
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        n_cells = 0;
        n_free = 0;
        n_submerged = 0;
        n_dry = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dry link, free law, submerged law, both signs, extremes
        queue_link(make_link('0, '0, '0, '0, 32'd1, 1'b1));
        queue_link(make_link(31'h0002_0000, '0, '0, '0, 32'd4, 1'b0));
        queue_link(make_link(31'h0002_0000, '0, 31'h0001_C000, '0, 32'd4, 1'b1));
        queue_link(make_link(31'h0001_0000, '0, 31'h0003_0000, '0, 32'd1, 1'b1));
        queue_link(make_link(31'h0001_8000, '0, 31'h0001_0000, '0, 32'd2, 1'b1));
        queue_link(make_link(31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                             32'h8000_0000, 32'd1, 1'b1));
        queue_link(make_link(31'h7FFF_FFFF, 32'h8000_0000, '0, 32'h7FFF_FFFF,
                             32'hFFFF_FFFF, 1'b1));
        queue_link(make_link('0, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000,
                             '0, 1'b1));
        // large totals: six capped outflows, then four capped inflows, each cell with a small area
        for (int k = 0; k < 6; k++)
            queue_link(make_link(31'h7FFF_FFFF, 32'h7FFF_FFFF, '0,
                                 32'h8000_0000, 32'd1, k == 5));
        for (int k = 0; k < 4; k++)
            queue_link(make_link('0, 32'h8000_0000, 31'h7FFF_FFFF,
                                 32'h7FFF_FFFF, '0, k == 3));
        queue_link(make_link(31'h0005_0000, '0, 31'h0004_0000, '0, 32'd1, 1'b1));
        wait_drained();

        coef_set  = '{32'd1638, 32'd0, 32'd65535, 32'd4096};
        crest_set = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000};
        queued = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 4)
            begin
                write_reg(CFG_WEIR_COEF, coef_set[ph]);
                write_reg(CFG_CREST_OFFSET, crest_set[(ph + 1) % 4]);
            end
            else
            begin
                write_reg(CFG_WEIR_COEF, $urandom_range(0, 65535));
                write_reg(CFG_CREST_OFFSET,
                          ($urandom_range(0, 3) == 0) ? $urandom
                                                      : $urandom_range(0, 32'h0003_0000)
                                                        - 32'h0001_8000);
            end
            while (queued < (ph + 1) * N_RANDOM / 8)
            begin
                queue_cell();
                queued = n_sent + link_queue.size() + (in_valid ? 1 : 0);
            end
            wait_drained();
        end

        $display("Covered %0d links in %0d cells: %0d free, %0d submerged, %0d dry.",
                 n_sent, n_cells, n_free, n_submerged, n_dry);
        $display("Eight register settings, including coefficient and crest extremes.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout after %0d links", n_sent);
        $display("Regression FAIL");
        $finish;
    end

endmodule
